// ===== rtl/vcec_pkg.sv =====
// Package for the void-closure evaporation cap block.
// Holds the store depth, register index codes and the payload structs.
// No dependencies.
`default_nettype none
package vcec_pkg;

    localparam int CELLS = 4096;
    localparam int IDX_W = $clog2(CELLS);

    localparam logic [16:0] RAMP_BAND_RST   = 17'd13107;
    localparam logic [24:0] VOID_OPEN_RST   = 25'd17;
    localparam logic [24:0] VOID_CLOSED_RST = 25'd1;

    typedef enum logic [1:0] {
        REG_RAMP_BAND   = 2'd0,
        REG_VOID_OPEN   = 2'd1,
        REG_VOID_CLOSED = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic        [11:0] cell_index;
        logic        [24:0] melt_fraction;
        logic        [31:0] mixture_density;
        logic        [31:0] melt_density;
        logic signed [31:0] cell_pressure;
        logic signed [31:0] saturation_pressure;
    } in_item_t;

    typedef struct packed {
        logic [16:0] evaporation_cap;
        logic [24:0] closure_void;
        logic        reference_armed;
    } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/void_closure_evaporation_cap.sv =====
// Top level of the void-closure evaporation cap block.
// Depends on vcec_pkg for types and constants.
`default_nettype none
// Usage
// - in_valid/in_ready/in_data: one mesh cell per transfer. The block keeps a
//   reference density per cell in a 4096 x 32 single-port-write memory with
//   a registered read, updates it and reports closure void and cap.
// - out_valid/out_ready/out_data: one result per input transfer, in order.
// - cfg_valid/cfg_ready/cfg_index/cfg_data: register writes, always ready;
//   write only while the block is idle. Index 3 is ignored.
// Processing
// - One item at a time. A cell whose closure is zero goes from accept
//   through the update to the result register; otherwise the update is
//   followed by the closure divider (one quotient bit a cycle), multiply,
//   compare and, unless the cap is zero or saturates, the cap divider.
// - The result register parts the sides: the next item is taken while a
//   result waits to be taken, and a finished item holds until the register
//   frees.
// Reset
// - After rst_n releases, a clearing pass writes zero to all 4096 entries,
//   one per cycle; no item is accepted meanwhile.
// Stall
// - With out_ready low the result holds; at most one more item completes
//   and waits in its final state.
module void_closure_evaporation_cap
    import vcec_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [24:0] cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_UPDATE, S_CDIV, S_MUL, S_CAP, S_QDIV, S_DONE
    } state_t;

    state_t      state_reg;
    logic [IDX_W-1:0] clr_reg;
    logic [16:0] band_reg;
    logic [24:0] open_reg;
    logic [24:0] closed_reg;

    in_item_t    item_reg;
    logic [31:0] mem [CELLS];
    logic [31:0] rd_reg;
    logic        armed_reg;
    logic [32:0] crem_reg;
    logic [23:0] cq_reg;
    logic [4:0]  cnt_reg;
    logic signed [25:0] num_reg;
    logic [40:0] den_reg;
    logic [41:0] qrem_reg;
    logic [15:0] qq_reg;
    logic [16:0] cap_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    logic signed [25:0] void_now;
    logic [31:0] ref_next;
    logic        mem_we;
    logic [IDX_W-1:0] mem_wa, mem_ra;
    logic [31:0] mem_wd;
    logic [32:0] crem_sh;
    logic [41:0] qrem_sh;
    logic [16:0] band_eff;
    logic        out_free;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        void_now = 26'sd16777216 - $signed({1'b0, item_reg.melt_fraction});
        ref_next = rd_reg;
        if (rd_reg == 32'd0)
        begin
            if (void_now > $signed({1'b0, open_reg}) ||
                item_reg.cell_pressure <= item_reg.saturation_pressure)
                ref_next = item_reg.mixture_density;
        end
        else if (void_now < $signed({1'b0, closed_reg}) &&
                 item_reg.cell_pressure > item_reg.saturation_pressure)
        begin
            ref_next = 32'd0;
        end
        band_eff = (band_reg == 17'd0) ? 17'd1 : band_reg;
        crem_sh  = {crem_reg[31:0], 1'b0};
        qrem_sh  = {qrem_reg[40:0], 1'b0};
    end

    // Memory port: clearing pass or write-back of the updated reference.
    assign mem_we = (state_reg == S_CLEAR) || (state_reg == S_UPDATE);
    assign mem_wa = (state_reg == S_CLEAR) ? clr_reg : item_reg.cell_index[IDX_W-1:0];
    assign mem_wd = (state_reg == S_CLEAR) ? 32'd0 : ref_next;
    assign mem_ra = (state_reg == S_IDLE) ? in_data.cell_index[IDX_W-1:0]
                                          : item_reg.cell_index[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            band_reg      <= RAMP_BAND_RST;
            open_reg      <= VOID_OPEN_RST;
            closed_reg    <= VOID_CLOSED_RST;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_RAMP_BAND:   band_reg   <= cfg_data[16:0];
                    REG_VOID_OPEN:   open_reg   <= cfg_data;
                    REG_VOID_CLOSED: closed_reg <= cfg_data;
                    default: ;
                endcase
            end
            // Release the output register; the final state refills it itself.
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IDX_W'(CELLS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_data;
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    // Hold the new reference; skip the dividers on zero closure.
                    armed_reg <= (ref_next != 32'd0);
                    cq_reg    <= '0;
                    cap_reg   <= '0;
                    cnt_reg   <= '0;
                    crem_reg  <= {1'b0, item_reg.melt_density - ref_next};
                    if (ref_next == 32'd0 || item_reg.melt_density == 32'd0 ||
                        ref_next >= item_reg.melt_density)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_CDIV;
                end
                S_CDIV:
                begin
                    if (crem_sh >= {1'b0, item_reg.melt_density})
                    begin
                        crem_reg <= crem_sh - {1'b0, item_reg.melt_density};
                        cq_reg   <= {cq_reg[22:0], 1'b1};
                    end
                    else
                    begin
                        crem_reg <= crem_sh;
                        cq_reg   <= {cq_reg[22:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd23)
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    den_reg   <= 41'(band_eff * cq_reg);
                    num_reg   <= $signed({2'b00, cq_reg}) - void_now;
                    state_reg <= S_CAP;
                end
                S_CAP:
                begin
                    cnt_reg  <= '0;
                    qq_reg   <= '0;
                    qrem_reg <= {1'b0, num_reg[24:0], 16'd0};
                    if (num_reg <= 26'sd0)
                        state_reg <= S_DONE;
                    else if ({num_reg[24:0], 16'd0} >= den_reg)
                    begin
                        cap_reg   <= 17'd65536;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_QDIV;
                end
                S_QDIV:
                begin
                    if (qrem_sh >= {1'b0, den_reg})
                    begin
                        qrem_reg <= qrem_sh - {1'b0, den_reg};
                        qq_reg   <= {qq_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        qrem_reg <= qrem_sh;
                        qq_reg   <= {qq_reg[14:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd15)
                    begin
                        cap_reg   <= {1'b0, qq_reg[14:0], (qrem_sh >= {1'b0, den_reg})};
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // Drop the result into the output register once it frees.
                    if (out_free)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_reg.evaporation_cap  <= cap_reg;
                        out_reg.closure_void     <= {1'b0, cq_reg};
                        out_reg.reference_armed  <= armed_reg;
                        state_reg                <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("item accepted during clearing pass");

    a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.evaporation_cap <= 17'd65536))
        else $error("cap above full rate");

    a_unarmed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.reference_armed) |->
        (out_data.closure_void == 25'd0 && out_data.evaporation_cap == 17'd0))
        else $error("unarmed cell with nonzero result");

    a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_UPDATE))
        else $error("accepted item skipped its update");

endmodule
`default_nettype wire
